// File: design/positional_list_store_unit_defines.svh
// Assertion macros for the positional list store unit
`ifndef POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PLSU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plsu: same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PLSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plsu: next-cycle check failed");

`endif

// File: design/plsu_pkg.sv
// Shared types and constants of the positional list store unit
`default_nettype none

package plsu_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int OP_W   = 2;
  localparam int POS_W  = 5;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_GET    = 2'd2;
  localparam op_t OP_CLEAR  = 2'd3;

  localparam status_t STAT_OK   = 2'd0;
  localparam status_t STAT_BAD  = 2'd1;
  localparam status_t STAT_FULL = 2'd2;

endpackage

`default_nettype wire

// File: design/plsu_in_if.sv
// Request channel interface of the positional list store unit
`default_nettype none

interface plsu_in_if;
  logic                          valid;
  logic                          ready;
  plsu_pkg::op_t                 op;
  logic [plsu_pkg::POS_W-1:0]    position;
  logic [plsu_pkg::DATA_W-1:0]   value_in;

  modport source (output valid, output op, output position, output value_in, input ready);
  modport sink   (input valid, input op, input position, input value_in, output ready);
endinterface

`default_nettype wire

// File: design/plsu_out_if.sv
// Result channel interface of the positional list store unit
`default_nettype none

interface plsu_out_if;
  logic                          valid;
  logic                          ready;
  logic [plsu_pkg::DATA_W-1:0]   value_out;
  logic [plsu_pkg::POS_W-1:0]    entry_count;
  plsu_pkg::status_t             status;

  modport source (output valid, output value_out, output entry_count, output status,
                  input ready);
  modport sink   (input valid, input value_out, input entry_count, input status,
                  output ready);
endinterface

`default_nettype wire

// File: design/plsu_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle
`default_nettype none

module plsu_ram #(
  parameter int WIDTH = plsu_pkg::VALUE_WIDTH_DEF,
  parameter int DEPTH = plsu_pkg::CAPACITY_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/positional_list_store_unit.sv
// Positional list store unit: bounded ordered list with insert, remove, get, clear
//
// Requests arrive on in_ch (op, position, value_in) and each gives exactly one
// transfer on out_ch (value_out, entry_count, status). A transfer happens when
// valid and ready are both high at a rising edge of clk.
// The list lives in one RAM with registered read; insert and remove move the
// later entries one place per cycle through that RAM's read and write ports.
// in_ch.ready is high whenever no request is in progress, also while a result
// still waits on out_ch.
// Clear and refused requests go straight to the result. Get, insert and remove
// first pass through S_RUN, which reads the addressed entry for get and moves the
// entries at or after the position (count - position of them) for insert and
// remove; an insert at the end moves none. A new request is taken only after the
// result of the last one is loaded into the output register.
// A stalled receiver holds the result in the output register; the block then
// finishes the next request and waits with it until the register frees up.
// Reset (rst_n low, synchronous) empties the list and drops any result; the
// RAM content is not cleared and needs no clearing pass.
`default_nettype none
`include "positional_list_store_unit_defines.svh"

module positional_list_store_unit #(
  parameter int CAPACITY    = plsu_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = plsu_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  plsu_in_if.sink     in_ch,
  plsu_out_if.source  out_ch
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = plsu_pkg::POS_W;
  localparam int DW = plsu_pkg::DATA_W;
  localparam int VW = VALUE_WIDTH;
  localparam int XW = PW + CW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           rem_r, rem_nxt;
  logic                    wb_vld_r, wb_vld_nxt;
  logic                    out_valid_r, out_valid_nxt;

  plsu_pkg::op_t           op_r, op_nxt;
  logic [AW-1:0]           pos_r, pos_nxt;
  logic [VW-1:0]           val_r, val_nxt;
  logic [AW-1:0]           src_r, src_nxt;
  logic [AW-1:0]           wb_src_r, wb_src_nxt;
  logic [VW-1:0]           res_val_r, res_val_nxt;
  plsu_pkg::status_t       res_st_r, res_st_nxt;
  logic [DW-1:0]           out_value_r, out_value_nxt;
  logic [PW-1:0]           out_count_r, out_count_nxt;
  plsu_pkg::status_t       out_status_r, out_status_nxt;

  logic                    in_fire;
  logic                    out_fire;
  logic                    out_free;
  logic [XW-1:0]           pos_x;
  logic [XW-1:0]           cnt_x;
  logic [CW-1:0]           cnt_dec;
  logic [CW-1:0]           rem_init;
  logic [VW+DW-1:0]        val_in_x;
  logic [DW+VW-1:0]        res_val_x;
  logic [PW+CW-1:0]        count_x;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [VW-1:0]           ram_wdata;
  logic [VW-1:0]           ram_rdata;

  plsu_ram #(
    .WIDTH (VW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (src_r),
    .rdata (ram_rdata)
  );

  assign in_ch.ready      = (state_r == S_IDLE);
  assign in_fire          = in_ch.valid && in_ch.ready;
  assign out_fire         = out_valid_r && out_ch.ready;
  assign out_free         = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.value_out   = out_value_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.status      = out_status_r;

  assign pos_x     = {{CW{1'b0}}, in_ch.position};
  assign cnt_x     = {{PW{1'b0}}, count_r};
  assign cnt_dec   = count_r - CW'(1);
  assign rem_init  = count_r - pos_x[CW-1:0];
  assign val_in_x  = {{VW{1'b0}}, in_ch.value_in};
  assign res_val_x = {{DW{1'b0}}, res_val_r};
  assign count_x   = {{PW{1'b0}}, count_r};

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rem_nxt        = rem_r;
    wb_vld_nxt     = wb_vld_r;
    out_valid_nxt  = out_valid_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    src_nxt        = src_r;
    wb_src_nxt     = wb_src_r;
    res_val_nxt    = res_val_r;
    res_st_nxt     = res_st_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = val_r;

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt      = in_ch.op;
          pos_nxt     = pos_x[AW-1:0];
          val_nxt     = val_in_x[VW-1:0];
          res_val_nxt = '0;
          res_st_nxt  = plsu_pkg::STAT_OK;
          wb_vld_nxt  = 1'b0;
          state_nxt   = S_DONE;
          case (in_ch.op)
            plsu_pkg::OP_INSERT: begin
              if (pos_x > cnt_x) begin
                res_st_nxt = plsu_pkg::STAT_BAD;
              end else if (cnt_x >= XW'(CAPACITY)) begin
                res_st_nxt = plsu_pkg::STAT_FULL;
              end else begin
                count_nxt = count_r + CW'(1);
                rem_nxt   = rem_init;
                src_nxt   = cnt_dec[AW-1:0];
                state_nxt = S_RUN;
              end
            end
            plsu_pkg::OP_REMOVE: begin
              if (pos_x >= cnt_x) begin
                res_st_nxt = plsu_pkg::STAT_BAD;
              end else begin
                count_nxt = cnt_dec;
                rem_nxt   = rem_init;
                src_nxt   = pos_x[AW-1:0];
                state_nxt = S_RUN;
              end
            end
            plsu_pkg::OP_GET: begin
              if (pos_x >= cnt_x) begin
                res_st_nxt = plsu_pkg::STAT_BAD;
              end else begin
                rem_nxt   = CW'(1);
                src_nxt   = pos_x[AW-1:0];
                state_nxt = S_RUN;
              end
            end
            default: begin
              count_nxt = '0;
            end
          endcase
        end
      end

      S_RUN: begin
        // read issue: one entry per cycle, data back next cycle
        if (rem_r != '0) begin
          wb_vld_nxt = 1'b1;
          wb_src_nxt = src_r;
          rem_nxt    = rem_r - CW'(1);
          src_nxt    = (op_r == plsu_pkg::OP_INSERT) ? src_r - AW'(1) : src_r + AW'(1);
        end else begin
          wb_vld_nxt = 1'b0;
        end

        // write back of the moved entry, or capture of the addressed one
        if (wb_vld_r) begin
          ram_wdata = ram_rdata;
          if (op_r == plsu_pkg::OP_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = wb_src_r + AW'(1);
          end else if (wb_src_r == pos_r) begin
            res_val_nxt = ram_rdata;
          end else begin
            ram_we    = (op_r == plsu_pkg::OP_REMOVE);
            ram_waddr = wb_src_r - AW'(1);
          end
        end

        if (rem_r == '0 && !wb_vld_r) begin
          if (op_r == plsu_pkg::OP_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = pos_r;
            ram_wdata = val_r;
          end
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_val_x[DW-1:0];
          out_count_nxt  = count_x[PW-1:0];
          out_status_nxt = res_st_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      wb_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      wb_vld_r    <= wb_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    src_r        <= src_nxt;
    wb_src_r     <= wb_src_nxt;
    res_val_r    <= res_val_nxt;
    res_st_r     <= res_st_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  `PLSU_ASSERT_SAME(a_count_cap, 1'b1, count_r <= CW'(CAPACITY))
  `PLSU_ASSERT_SAME(a_wb_in_run, wb_vld_r, state_r == S_RUN)
  `PLSU_ASSERT_SAME(a_we_in_run, ram_we, state_r == S_RUN)
  `PLSU_ASSERT_NEXT(a_done_loads, (state_r == S_DONE) && out_free, out_valid_r && (state_r == S_IDLE))

endmodule

`default_nettype wire
